// ===== src/trcd_pkg.sv =====
// Package: shared types and constants of the tick-rate calibrate and delay unit.
package trcd_pkg;

  // Command kinds that survive front-end classification
  typedef enum logic [1:0] {
    KIND_CAL = 2'd0,
    KIND_DLY = 2'd1,
    KIND_SMP = 2'd2
  } kind_e;

  // Raw request codes on the input channel
  localparam logic [1:0] REQ_CAL = 2'd0;
  localparam logic [1:0] REQ_DLY = 2'd1;
  localparam logic [1:0] REQ_SMP = 2'd2;

  // Result kinds
  localparam logic DONE_CAL = 1'b0;
  localparam logic DONE_DLY = 1'b1;

  localparam int unsigned RATE_W  = 23;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned MS_W    = 32;
  localparam int unsigned TOTAL_W = 48;

  localparam logic [RATE_W-1:0] RATE_RESET  = 23'd1193;
  localparam logic [SUM_W-1:0]  CAL_DIVISOR = 32'd1000;
  localparam logic [SUM_W-1:0]  SUM_MAX     = 32'hFFFF_FFFF;

  // floor(x / 1000) == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
  localparam int unsigned       MAGIC_W   = 29;
  localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'd274877907;
  localparam int unsigned       DIV_SHIFT = 38;
  localparam int unsigned       PROD_W    = SUM_W + MAGIC_W;

  // Command queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] ms_count;
    logic [15:0] counter_value;
    logic [7:0]  rtc_seconds;
  } item_t;

endpackage

// ===== src/trcd_ifs.sv =====
// Interfaces: request and result channels with valid/ready handshake.
interface trcd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] ms_count;
  logic [15:0] counter_value;
  logic [7:0]  rtc_seconds;

  modport source (output valid, req_type, ms_count, counter_value, rtc_seconds,
                  input ready);
  modport sink (input valid, req_type, ms_count, counter_value, rtc_seconds,
                output ready);
endinterface

interface trcd_rsp_if;
  logic        valid;
  logic        ready;
  logic        done_kind;
  logic        cal_accepted;
  logic [22:0] rate_ticks_per_ms;
  logic [47:0] elapsed_ms_total;

  modport source (output valid, done_kind, cal_accepted, rate_ticks_per_ms,
                  elapsed_ms_total, input ready);
  modport sink (input valid, done_kind, cal_accepted, rate_ticks_per_ms,
                elapsed_ms_total, output ready);
endinterface

// ===== src/trcd_front.sv =====
// Front end: accepts request beats, drops unused codes, classifies the rest.
module trcd_front
  import trcd_pkg::*;
(
  trcd_req_if.sink req_i,
  output logic     push_valid_o,
  output item_t    push_item_o,
  input  logic     push_ready_i
);

  logic keep;

  assign req_i.ready = push_ready_i;

  always_comb begin
    keep                      = 1'b1;
    push_item_o.kind          = KIND_SMP;
    push_item_o.ms_count      = req_i.ms_count;
    push_item_o.counter_value = req_i.counter_value;
    push_item_o.rtc_seconds   = req_i.rtc_seconds;
    unique case (req_i.req_type)
      REQ_CAL: push_item_o.kind = KIND_CAL;
      REQ_DLY: push_item_o.kind = KIND_DLY;
      REQ_SMP: push_item_o.kind = KIND_SMP;
      default: keep = 1'b0;  // unused code: taken and dropped
    endcase
  end

  assign push_valid_o = req_i.valid & keep;

endmodule

// ===== src/trcd_fifo.sv =====
// Command queue: small FIFO decoupling the front end from the back end.
module trcd_fifo
  import trcd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  input  item_t push_item_i,
  output logic  push_ready_o,
  output logic  pop_valid_o,
  output item_t pop_item_o,
  input  logic  pop_ready_i
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== src/trcd_back.sv =====
// Back end: calibration / delay sequencer, reciprocal divide, result register.
module trcd_back
  import trcd_pkg::*;
#(
  parameter int COUNTER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        item_ready_o,
  trcd_rsp_if.source  rsp_o
);

  localparam int unsigned CB = COUNTER_BITS;
  localparam int unsigned DW = CB + 1;
  localparam int unsigned AW = ((DW > SUM_W) ? DW : SUM_W) + 1;
  localparam logic [CB-1:0] CNT_MAX = '1;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_CAL_REF  = 7'b0000010,
    PH_CAL_WAIT = 7'b0000100,
    PH_CAL_SUM  = 7'b0001000,
    PH_CAL_DIV  = 7'b0010000,
    PH_DLY_ARM  = 7'b0100000,
    PH_DLY_CNT  = 7'b1000000
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [7:0]           ref_sec_q, ref_sec_d;
  logic [CB-1:0]        prev_q, prev_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [RATE_W-1:0]    rate_q, rate_d;
  logic [MS_W-1:0]      left_q, left_d;
  logic [MS_W-1:0]      reqd_q, reqd_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic                 ok_q, ok_d;
  logic [PROD_W-1:0]    prod_q;

  logic                 out_valid_q, out_valid_d;
  logic                 out_kind_q, out_acc_q;
  logic [RATE_W-1:0]    out_rate_q;
  logic [TOTAL_W-1:0]   out_total_q;

  logic                 slot_free, pop, emit, emit_kind, emit_acc;
  logic [CB+15:0]       cnt_ext;
  logic [CB-1:0]        cur;
  logic [DW-1:0]        delta;
  logic [AW-1:0]        acc;
  logic [SUM_W-1:0]     sum_sat;
  logic [MS_W-1:0]      left_dec;

  // Counter reading masked to COUNTER_BITS
  assign cnt_ext = {{CB{1'b0}}, item_i.counter_value};
  assign cur     = cnt_ext[CB-1:0];

  // Down-counter delta with the wrap rule prev + (M - cur)
  always_comb begin
    if (cur > prev_q) begin
      delta = {1'b0, prev_q} + ({1'b0, CNT_MAX} - {1'b0, cur});
    end else begin
      delta = {1'b0, prev_q} - {1'b0, cur};
    end
  end

  assign acc      = AW'(sum_q) + AW'(delta);
  assign sum_sat  = (acc > AW'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
  assign left_dec = left_q - 1'b1;

  assign slot_free    = !out_valid_q || rsp_o.ready;
  assign pop          = item_valid_i && slot_free && (phase_q != PH_CAL_DIV);
  assign item_ready_o = slot_free && (phase_q != PH_CAL_DIV);

  always_comb begin
    phase_d   = phase_q;
    ref_sec_d = ref_sec_q;
    prev_d    = prev_q;
    sum_d     = sum_q;
    rate_d    = rate_q;
    left_d    = left_q;
    reqd_d    = reqd_q;
    total_d   = total_q;
    ok_d      = ok_q;
    emit      = 1'b0;
    emit_kind = DONE_CAL;
    emit_acc  = 1'b0;

    if (phase_q == PH_CAL_DIV) begin
      // product of the final sum is registered now
      if (slot_free) begin
        if (ok_q) begin
          rate_d = prod_q[DIV_SHIFT +: RATE_W];
        end
        emit      = 1'b1;
        emit_kind = DONE_CAL;
        emit_acc  = ok_q;
        phase_d   = PH_IDLE;
      end
    end else if (pop) begin
      unique case (item_i.kind)
        KIND_CAL: begin
          if (phase_q == PH_IDLE) begin
            phase_d = PH_CAL_REF;
          end
        end
        KIND_DLY: begin
          if (phase_q == PH_IDLE) begin
            if (item_i.ms_count == '0) begin
              emit      = 1'b1;
              emit_kind = DONE_DLY;
            end else begin
              left_d  = item_i.ms_count;
              reqd_d  = item_i.ms_count;
              sum_d   = '0;
              phase_d = PH_DLY_ARM;
            end
          end
        end
        KIND_SMP: begin
          unique case (phase_q)
            PH_CAL_REF: begin
              ref_sec_d = item_i.rtc_seconds;
              phase_d   = PH_CAL_WAIT;
            end
            PH_CAL_WAIT: begin
              if (item_i.rtc_seconds != ref_sec_q) begin
                ref_sec_d = item_i.rtc_seconds;
                prev_d    = cur;
                sum_d     = '0;
                phase_d   = PH_CAL_SUM;
              end
            end
            PH_CAL_SUM: begin
              if (item_i.rtc_seconds == ref_sec_q) begin
                sum_d  = sum_sat;
                prev_d = cur;
              end else begin
                ok_d    = (sum_q > CAL_DIVISOR);
                phase_d = PH_CAL_DIV;
              end
            end
            PH_DLY_ARM: begin
              prev_d  = cur;
              sum_d   = '0;
              phase_d = PH_DLY_CNT;
            end
            PH_DLY_CNT: begin
              sum_d  = sum_sat;
              prev_d = cur;
              if (sum_sat >= SUM_W'(rate_q)) begin
                left_d = left_dec;
                if (left_dec != '0) begin
                  phase_d = PH_DLY_ARM;
                end else begin
                  total_d   = total_q + TOTAL_W'(reqd_q);
                  phase_d   = PH_IDLE;
                  emit      = 1'b1;
                  emit_kind = DONE_DLY;
                end
              end
            end
            default: ;  // idle: sample ignored
          endcase
        end
        default: ;
      endcase
    end

    out_valid_d = out_valid_q && !rsp_o.ready;
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      ref_sec_q   <= '0;
      prev_q      <= '0;
      sum_q       <= '0;
      rate_q      <= RATE_RESET;
      left_q      <= '0;
      reqd_q      <= '0;
      total_q     <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      ref_sec_q   <= ref_sec_d;
      prev_q      <= prev_d;
      sum_q       <= sum_d;
      rate_q      <= rate_d;
      left_q      <= left_d;
      reqd_q      <= reqd_d;
      total_q     <= total_d;
      ok_q        <= ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Reciprocal multiply for the divide by 1000; result register loads
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(sum_q) * PROD_W'(DIV_MAGIC);
    if (emit) begin
      out_kind_q  <= emit_kind;
      out_acc_q   <= emit_acc;
      out_rate_q  <= rate_d;
      out_total_q <= total_d;
    end
  end

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.done_kind         = out_kind_q;
  assign rsp_o.cal_accepted      = out_acc_q;
  assign rsp_o.rate_ticks_per_ms = out_rate_q;
  assign rsp_o.elapsed_ms_total  = out_total_q;

endmodule

// ===== src/tick_rate_calibrate_and_delay_unit.sv =====
// Top level: tick-rate calibration and millisecond delay engine.
//
// Request beats (start calibration, start delay, counter/seconds sample) are
// taken by a front end that drops the unused request code and pushes the rest
// into a two-entry command queue. The back end pops one command per cycle and
// runs the calibration and delay sequencer: each sample costs one wrap-
// corrected counter delta, a saturating 32-bit add and a compare against the
// current rate. Throughput is one beat per clock while the result channel
// takes results. At the end of a calibration the back end stalls while the
// tick sum goes through a registered reciprocal multiply (divide by 1000)
// before the new rate and the result are written; the queue absorbs incoming
// beats meanwhile. Results sit in an output register, so the block keeps
// accepting beats until the queue fills while a result waits. Commands that
// arrive while an operation runs are dropped, as are samples while idle.
// COUNTER_BITS sets the width of the sampled counter.
module tick_rate_calibrate_and_delay_unit
  import trcd_pkg::*;
#(
  parameter int COUNTER_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  trcd_req_if.sink   req_i,
  trcd_rsp_if.source rsp_o
);

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  // Classify and filter incoming beats
  trcd_front u_front (
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  // Command queue lets the front and back stall independently
  trcd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  // Sequencer, divider and result register
  trcd_back #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (pop_valid),
    .item_i       (pop_item),
    .item_ready_o (pop_ready),
    .rsp_o        (rsp_o)
  );

endmodule

// ===== test/tick_rate_calibrate_and_delay_unit_tb.sv =====
// Testbench: tick-rate calibrate and delay unit, checked beat by beat against a predictor.
module tick_rate_calibrate_and_delay_unit_tb;
  import trcd_pkg::*;

  localparam int          COUNTER_BITS = 16;
  localparam logic [15:0] CNT_MAX      = 16'hFFFF;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;   // selector the front end drops
  localparam int          RST_CYCLES   = 12;
  localparam int          DRAIN_CYCLES = 12;     // final wait before the verdict
  localparam int          HOLD_CYCLES  = 400;    // long result hold-off to back up the queue
  localparam int          WIDE_SAMPLES = 100;    // near-0xFFFE deltas for a large tick sum
  localparam int          PHASE_BEATS  = 250;
  localparam longint      RUN_LIMIT    = 24_000_000;

  // Engine phases of the predictor
  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_CAL_REF,
    ENG_CAL_WAIT,
    ENG_CAL_SUM,
    ENG_DLY_ARM,
    ENG_DLY_COUNT
  } eng_phase_e;

  typedef struct packed {
    logic               kind;
    logic               acc;
    logic [RATE_W-1:0]  rate;
    logic [TOTAL_W-1:0] total;
  } done_t;

  // Predicts completion beats from accepted requests and checks them in order.
  class done_scoreboard;
    eng_phase_e          eng       = ENG_IDLE;
    logic [7:0]          sec_ref   = '0;
    logic [15:0]         last_cnt  = '0;
    longint unsigned     tick_sum  = 0;
    logic [RATE_W-1:0]   rate      = RATE_RESET;
    logic [MS_W-1:0]     ms_left   = '0;
    logic [MS_W-1:0]     ms_asked  = '0;
    logic [TOTAL_W-1:0]  ms_total  = '0;
    done_t               expected[$];
    int unsigned         errors    = 0;

    function void log_done(logic kind, logic acc);
      expected.push_back({kind, acc, rate, ms_total});
    endfunction

    // down-counter delta; a wrap loses one tick
    function void add_ticks(logic [15:0] cnt);
      longint unsigned d;
      if (cnt > last_cnt) d = {48'b0, last_cnt} + {48'b0, CNT_MAX - cnt};
      else d = {48'b0, last_cnt - cnt};
      tick_sum = tick_sum + d;
      if (tick_sum > SUM_MAX) tick_sum = SUM_MAX;
      last_cnt = cnt;
    endfunction

    // Returns 1 when the beat did something, 0 when the block drops it.
    function bit absorb_beat(logic [1:0] req, logic [31:0] ms, logic [15:0] cnt,
                             logic [7:0] sec);
      bit ok;
      if (req == REQ_CAL || req == REQ_DLY) begin
        if (eng != ENG_IDLE) return 1'b0;
        if (req == REQ_CAL) eng = ENG_CAL_REF;
        else if (ms == '0) log_done(DONE_DLY, 1'b0);
        else begin
          ms_left  = ms;
          ms_asked = ms;
          tick_sum = 0;
          eng      = ENG_DLY_ARM;
        end
        return 1'b1;
      end
      if (req != REQ_SMP || eng == ENG_IDLE) return 1'b0;
      case (eng)
        ENG_CAL_REF: begin
          sec_ref = sec;
          eng     = ENG_CAL_WAIT;
        end
        ENG_CAL_WAIT: begin
          if (sec != sec_ref) begin
            sec_ref  = sec;
            last_cnt = cnt;
            tick_sum = 0;
            eng      = ENG_CAL_SUM;
          end
        end
        ENG_CAL_SUM: begin
          // seconds checked first: the closing sample adds no ticks
          if (sec == sec_ref) add_ticks(cnt);
          else begin
            ok = tick_sum > CAL_DIVISOR;
            if (ok) rate = RATE_W'(tick_sum / CAL_DIVISOR);
            eng = ENG_IDLE;
            log_done(DONE_CAL, ok);
          end
        end
        ENG_DLY_ARM: begin
          last_cnt = cnt;
          tick_sum = 0;
          eng      = ENG_DLY_COUNT;
        end
        ENG_DLY_COUNT: begin
          add_ticks(cnt);
          if (tick_sum >= rate) begin
            ms_left = ms_left - 1'b1;
            if (ms_left != '0) eng = ENG_DLY_ARM;
            else begin
              ms_total = ms_total + {16'b0, ms_asked};
              eng      = ENG_IDLE;
              log_done(DONE_DLY, 1'b0);
            end
          end
        end
        default: ;
      endcase
      return 1'b1;
    endfunction

    function void match(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_done(done_t got);
      done_t want;
      if (expected.size() == 0) begin
        $error("result beat with nothing expected: done_kind %0d", got.kind);
        errors++;
        return;
      end
      want = expected.pop_front();
      match("done_kind", want.kind, got.kind);
      match("cal_accepted", want.acc, got.acc);
      match("rate_ticks_per_ms", want.rate, got.rate);
      match("elapsed_ms_total", want.total, got.total);
    endfunction

    function bit is_idle();
      return eng == ENG_IDLE;
    endfunction

    function int unsigned pending();
      return expected.size();
    endfunction

    function int unsigned rate_now();
      return rate;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  trcd_req_if req_if ();
  trcd_rsp_if rsp_if ();

  tick_rate_calibrate_and_delay_unit #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  done_scoreboard sb = new;

  logic [15:0] ctr         = '0;  // last counter value put on the wire
  int unsigned live_beats  = 0;   // beats the block acted on
  int unsigned snd_pct     = 0;   // sender idle chance per cycle, percent
  int unsigned rcv_pct     = 0;   // receiver stall chance per cycle, percent
  int unsigned hold_cycles = 0;   // pending long hold-off on the result side

  always #6 clk_i = ~clk_i;

  // Result side: random stalls, plus a long hold-off counted down here.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        rsp_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rcv_pct);
      end
    end
  end

  // Every accepted result beat goes to the scoreboard; values are pre-edge here.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_if.valid && rsp_if.ready) begin
      sb.check_done({rsp_if.done_kind, rsp_if.cal_accepted, rsp_if.rate_ticks_per_ms,
                     rsp_if.elapsed_ms_total});
    end
  end

  // One request beat: optional idle gap, then hold valid until accepted.
  // valid stays high across back-to-back beats, only the payload changes.
  task automatic send_beat(input logic [1:0] req, input logic [31:0] ms,
                           input logic [15:0] cnt, input logic [7:0] sec);
    if ($urandom_range(99) < snd_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_pct);
    end
    req_if.valid         <= 1'b1;
    req_if.req_type      <= req;
    req_if.ms_count      <= ms;
    req_if.counter_value <= cnt;
    req_if.rtc_seconds   <= sec;
    do @(posedge clk_i); while (!req_if.ready);
    if (sb.absorb_beat(req, ms, cnt, sec)) live_beats++;
  endtask

  // Sample beat with the down-counter moved back by delta.
  task automatic send_sample(input int unsigned delta, input logic [7:0] sec);
    ctr = ctr - 16'(delta);
    send_beat(REQ_SMP, $urandom, ctr, sec);
  endtask

  // Sender pause: nothing offered until every expected result is in.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Push whatever operation is running to its end with random samples.
  task automatic settle();
    while (!sb.is_idle()) send_sample($urandom_range(1, 65535), 8'($urandom));
  endtask

  // Well-formed calibration with random content; n == 0 closes on the start sample.
  task automatic calibrate_seq();
    logic [7:0] sec;
    int         n;
    sec = 8'($urandom);
    n   = $urandom_range(0, 10);
    send_beat(REQ_CAL, $urandom, 16'($urandom), 8'($urandom));
    if ($urandom_range(3) == 0)
      send_beat($urandom_range(1) ? REQ_DLY : REQ_CAL, $urandom, 16'($urandom),
                8'($urandom));
    send_sample(0, sec);
    repeat ($urandom_range(0, 3)) send_sample($urandom_range(0, 65535), sec);
    sec = sec + 8'($urandom_range(1, 255));
    ctr = 16'($urandom);
    send_sample(0, sec);
    repeat (n) send_sample($urandom_range(0, (1 << $urandom_range(2, 16)) - 1), sec);
    send_sample($urandom_range(0, 65535), sec + 8'($urandom_range(1, 255)));
  endtask

  // Delay of ms milliseconds; deltas scaled to the current rate so each ms takes a few beats.
  task automatic delay_seq(input int unsigned ms);
    int unsigned lim;
    send_beat(REQ_DLY, ms, 16'($urandom), 8'($urandom));
    if (!sb.is_idle() && $urandom_range(3) == 0)
      send_beat($urandom_range(1) ? REQ_DLY : REQ_CAL, $urandom, 16'($urandom),
                8'($urandom));
    lim = (sb.rate_now() > 32767) ? 65535 : 2 * sb.rate_now();
    while (!sb.is_idle()) send_sample($urandom_range(0, lim), 8'($urandom));
  endtask

  // Stray beat of any kind; an idle-time delay start is kept short.
  task automatic noise_beat();
    logic [1:0]  req;
    logic [31:0] ms;
    req = 2'($urandom_range(0, 3));
    ms  = $urandom;
    if (req == REQ_DLY && sb.is_idle()) ms = $urandom_range(0, 3);
    send_beat(req, ms, 16'($urandom), 8'($urandom));
  endtask

  task automatic random_phase(input int unsigned n, input int unsigned s_pct,
                              input int unsigned r_pct, input bit squeeze);
    int unsigned start;
    int unsigned pick;
    snd_pct = s_pct;
    rcv_pct = r_pct;
    start   = live_beats;
    if (squeeze) begin
      // results back up behind the hold-off until the request side stalls
      settle();
      hold_cycles = HOLD_CYCLES;
      repeat (16) send_beat(REQ_DLY, '0, 16'($urandom), 8'($urandom));
    end
    while (live_beats - start < n) begin
      settle();
      pick = $urandom_range(99);
      if (pick < 40) calibrate_seq();
      else if (pick < 80)
        delay_seq(($urandom_range(9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3));
      else repeat ($urandom_range(1, 3)) noise_beat();
    end
    wait_drained();
  endtask

  initial begin
    rst_ni               <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.req_type      <= REQ_CAL;
    req_if.ms_count      <= '0;
    req_if.counter_value <= '0;
    req_if.rtc_seconds   <= '0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: dropped beats, zero delay, sums at and just over the threshold,
    // busy commands, wrap deltas during a two-millisecond delay.
    send_beat(REQ_SMP, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);  // sample while idle
    send_beat(REQ_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    send_beat(REQ_DLY, 32'h0, 16'h0000, 8'h00);           // zero delay, total unchanged
    send_beat(REQ_CAL, 32'h0, 16'h0000, 8'h00);
    send_beat(REQ_SMP, 32'h0, 16'h0000, 8'h00);           // seconds reference
    send_beat(REQ_SMP, 32'h0, 16'h0000, 8'h00);           // no change yet
    send_beat(REQ_CAL, 32'h0, 16'h0000, 8'h00);           // busy, dropped
    send_beat(REQ_DLY, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);   // busy, dropped
    send_beat(REQ_SMP, 32'h0, 16'h0000, 8'h01);           // summing starts
    send_beat(REQ_SMP, 32'h0, 16'hFFFF, 8'h01);           // wrap, zero delta
    send_beat(REQ_SMP, 32'h0, 16'hFC18, 8'h01);           // sum 999
    send_beat(REQ_SMP, 32'h0, 16'hFC17, 8'h01);           // sum 1000: not enough
    send_beat(REQ_SMP, 32'h0, 16'h0000, 8'hFF);           // closes, counter not added
    send_beat(REQ_CAL, 32'h0, 16'h0000, 8'h00);
    send_beat(REQ_SMP, 32'h0, 16'h1234, 8'h80);
    send_beat(REQ_SMP, 32'h0, 16'h1000, 8'h7F);
    send_beat(REQ_SMP, 32'h0, 16'h0C17, 8'h7F);           // sum 1001
    send_beat(REQ_SMP, 32'h0, 16'h0000, 8'h80);           // accepted, rate 1
    send_beat(REQ_DLY, 32'h2, 16'h0000, 8'h00);
    send_beat(REQ_SMP, 32'h0, 16'h0001, 8'hFF);           // arm
    send_beat(REQ_SMP, 32'h0, 16'h0001, 8'h00);           // no ticks
    send_beat(REQ_SMP, 32'h0, 16'hFFFF, 8'hFF);           // wrap, one tick: first ms
    send_beat(REQ_SMP, 32'h0, 16'h8000, 8'h00);           // arm
    send_beat(REQ_SMP, 32'h0, 16'h7FFF, 8'hFF);           // second ms, delay done
    wait_drained();

    // Large tick sum: counter stepping up by one gives 0xFFFE per sample,
    // which drives the rate into the thousands.
    send_beat(REQ_CAL, $urandom, 16'($urandom), 8'($urandom));
    send_beat(REQ_SMP, $urandom, 16'($urandom), 8'h10);
    ctr = '0;
    send_sample(0, 8'h11);
    repeat (WIDE_SAMPLES) send_sample(CNT_MAX, 8'h11);
    send_sample(0, 8'h12);
    delay_seq(2);
    calibrate_seq();
    settle();
    wait_drained();

    random_phase(PHASE_BEATS, 0, 0, 1'b1);
    random_phase(PHASE_BEATS, 61, 0, 1'b0);
    random_phase(PHASE_BEATS, 0, 61, 1'b0);
    random_phase(PHASE_BEATS, 6, 6, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #(RUN_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
src/trcd_pkg.sv
src/trcd_ifs.sv
src/trcd_front.sv
src/trcd_fifo.sv
src/trcd_back.sv
src/tick_rate_calibrate_and_delay_unit.sv
test/tick_rate_calibrate_and_delay_unit_tb.sv
